FILE: src/stts_pkg.sv
// Shared types and constants for the sorted table ternary search block.
// Used by the controller, the datapath and the top level; no dependencies.
package stts_pkg;

    localparam int DEPTH_DEF = 1024;  // default table depth
    localparam int IDX_W     = 10;    // entry_index, start_index, found_index width
    localparam int CNT_W     = 11;    // item_count width
    localparam int POS_W     = 12;    // internal position width, start + count fits
    localparam int DATA_W    = 32;

    // floor(x / 3) for x < 2048 as (x * 2731) >> 13
    localparam int RECIP_W   = 12;
    localparam int RECIP_3   = 2731;
    localparam int RECIP_SH  = 13;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] entry_value;
        logic [IDX_W-1:0]         start_index;
        logic [CNT_W-1:0]         item_count;
        logic signed [DATA_W-1:0] search_key;
    } t_req;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] found_index;
    } t_result;

    typedef struct packed {
        logic load;        // write one table entry
        logic capture;     // take a search item, clamp its range
        logic calc_third;  // register floor(count / 3)
        logic probe;       // issue both table reads, hold the probe positions
        logic update;      // narrow the range to one of the three parts
        logic rep_p1;      // report a match at the first probe
        logic rep_p2;      // report a match at the second probe
        logic rep_miss;    // report not found
    } t_cmd;

    typedef struct packed {
        logic eq1;
        logic eq2;
        logic cnt_zero;
        logic cnt_one;
    } t_status;

endpackage

FILE: src/stts_ctrl.sv
// Sequencer for the ternary search: steps each level through divide, probe, compare.
// Depends on stts_pkg for the command and status structs.
module stts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_req_type,
    input  stts_pkg::t_status i_status,
    output stts_pkg::t_cmd    o_cmd,
    output logic              o_busy
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_PROBE = 4'b0100,
        ST_CMP   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_req_type == stts_pkg::REQ_SEARCH) begin
                        o_cmd.capture = 1'b1;
                        n_state       = ST_DIV;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (i_status.cnt_zero) begin
                    o_cmd.rep_miss = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    o_cmd.calc_third = 1'b1;
                    n_state          = ST_PROBE;
                end
            end
            ST_PROBE: begin
                o_cmd.probe = 1'b1;
                n_state     = ST_CMP;
            end
            ST_CMP: begin
                if (i_status.eq1) begin
                    o_cmd.rep_p1 = 1'b1;
                    n_state      = ST_IDLE;
                end else if (i_status.eq2) begin
                    o_cmd.rep_p2 = 1'b1;
                    n_state      = ST_IDLE;
                end else if (i_status.cnt_one) begin
                    o_cmd.rep_miss = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    o_cmd.update = 1'b1;
                    n_state      = ST_DIV;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    a_report_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.rep_p1 || o_cmd.rep_p2 || o_cmd.rep_miss) |=> (r_state == ST_IDLE))
        else $error("search did not return to idle after reporting");

    a_probe_then_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |=> (r_state == ST_CMP))
        else $error("compare did not follow probe");

    a_one_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.rep_p1, o_cmd.rep_p2, o_cmd.rep_miss, o_cmd.update,
                    o_cmd.calc_third}) <= 1)
        else $error("conflicting datapath commands");

endmodule

FILE: src/stts_dp.sv
// Datapath for the ternary search: table memory, range registers, divide-by-3,
// probe compare and result register. Depends on stts_pkg.
module stts_dp #(
    parameter int TABLE_DEPTH = stts_pkg::DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stts_pkg::t_req    i_req,
    input  stts_pkg::t_cmd    i_cmd,
    output stts_pkg::t_status o_status,
    output logic              o_valid,
    output stts_pkg::t_result o_result
);

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int XW     = (AW > stts_pkg::POS_W) ? AW : stts_pkg::POS_W;
    localparam int POS_W  = stts_pkg::POS_W;
    localparam int CNT_W  = stts_pkg::CNT_W;
    localparam int PROD_W = stts_pkg::RECIP_SH + CNT_W;

    function automatic logic [AW-1:0] to_addr(input logic [POS_W-1:0] pos);
        logic [XW-1:0] wide;
        wide = XW'(pos);
        return wide[AW-1:0];
    endfunction

    logic signed [stts_pkg::DATA_W-1:0] mem [TABLE_DEPTH];

    logic [POS_W-1:0]                   r_start, r_p1, r_p2;
    logic [CNT_W-1:0]                   r_count, r_third;
    logic signed [stts_pkg::DATA_W-1:0] r_key, r_d1, r_d2;
    logic                               r_valid;
    stts_pkg::t_result                  r_result;

    logic [31:0]       c_start32, c_limit;
    logic [CNT_W-1:0]  c_count_clamp;
    logic [PROD_W-1:0] c_prod;
    logic [POS_W-1:0]  c_p1, c_p2, c_span;
    logic              c_load_ok;

    // Range clamp against the table end.
    assign c_start32 = 32'(i_req.start_index);
    assign c_limit   = 32'(TABLE_DEPTH) - c_start32;
    always_comb begin
        if (c_start32 >= 32'(TABLE_DEPTH)) begin
            c_count_clamp = '0;
        end else if (32'(i_req.item_count) > c_limit) begin
            c_count_clamp = c_limit[CNT_W-1:0];
        end else begin
            c_count_clamp = i_req.item_count;
        end
    end

    assign c_load_ok = (32'(i_req.entry_index) < 32'(TABLE_DEPTH));
    assign c_prod    = PROD_W'(r_count) * PROD_W'(stts_pkg::RECIP_3);
    assign c_p1      = r_start + POS_W'(r_third);
    assign c_p2      = c_p1 + POS_W'((r_count - r_third) >> 1);
    assign c_span    = r_p2 - r_p1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && c_load_ok) begin
            mem[to_addr(POS_W'(i_req.entry_index))] <= i_req.entry_value;
        end
        if (i_cmd.probe) begin
            r_d1 <= mem[to_addr(c_p1)];
            r_d2 <= mem[to_addr(c_p2)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_start <= POS_W'(i_req.start_index);
            r_count <= c_count_clamp;
            r_key   <= i_req.search_key;
        end else if (i_cmd.update) begin
            if (r_key < r_d1) begin
                r_count <= r_third + CNT_W'(1);
            end else if (r_key < r_d2) begin
                r_start <= r_p1 + POS_W'(1);
                r_count <= CNT_W'(c_span);
            end else begin
                r_start <= r_p2 + POS_W'(1);
                r_count <= r_count - r_third - CNT_W'(1) - CNT_W'(c_span);
            end
        end
        if (i_cmd.calc_third) begin
            r_third <= c_prod[stts_pkg::RECIP_SH +: CNT_W];
        end
        if (i_cmd.probe) begin
            r_p1 <= c_p1;
            r_p2 <= c_p2;
        end
    end

    // Result register: strobe for one cycle per search.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.rep_p1 | i_cmd.rep_p2 | i_cmd.rep_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rep_p1) begin
            r_result.found       <= 1'b1;
            r_result.found_index <= r_p1[stts_pkg::IDX_W-1:0];
        end else if (i_cmd.rep_p2) begin
            r_result.found       <= 1'b1;
            r_result.found_index <= r_p2[stts_pkg::IDX_W-1:0];
        end else if (i_cmd.rep_miss) begin
            r_result <= '0;
        end
    end

    assign o_status.eq1      = (r_d1 == r_key);
    assign o_status.eq2      = (r_d2 == r_key);
    assign o_status.cnt_zero = (r_count == '0);
    assign o_status.cnt_one  = (r_count == CNT_W'(1));
    assign o_valid           = r_valid;
    assign o_result          = r_result;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe lasted more than one cycle");

    a_miss_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_result.found) |-> (r_result.found_index == '0))
        else $error("not-found result carries a nonzero index");

    a_range_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> (r_count < $past(r_count)))
        else $error("search range did not shrink");

endmodule

FILE: src/sorted_table_ternary_search.sv
// Sorted table ternary search: a load writes one in-range table entry, busy stays low.
// A search steps each ternary level through divide, probe both reads and compare;
// a full 1024-entry range takes up to 8 levels, plus a divide step when the last split
// leaves an empty part, and an empty range is reported as not found without a probe.
// The next item is taken in the strobe cycle; the receiver cannot stall the result.
// Synchronous active-low reset clears the sequencer and strobe; table contents stay.
module sorted_table_ternary_search #(
    parameter int TABLE_DEPTH = stts_pkg::DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  stts_pkg::t_req    i_req,
    output logic              o_valid,
    output stts_pkg::t_result o_result
);

    // Command and status between the sequencer and the datapath.
    stts_pkg::t_cmd    w_cmd;
    stts_pkg::t_status w_status;

    // Sequencer: decode the item type in idle, then walk the search levels.
    stts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_busy     (busy)
    );

    // Datapath: hold the table, narrow the range, register the result.
    stts_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
